FILE: rtl/gcdd_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate delta decoder package
// Shared types and codes for the annotation coordinate delta decoder.
// ----------------------------------------------------------------------------
package gcdd_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned SeqW   = 8;
	localparam int unsigned KindW  = 3;
	localparam int unsigned FrameW = 2;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [KindW-1:0] KIND_GENE        = 3'd0;
	localparam logic [KindW-1:0] KIND_TRANSCRIPT  = 3'd1;
	localparam logic [KindW-1:0] KIND_EXON        = 3'd2;
	localparam logic [KindW-1:0] KIND_CDS         = 3'd3;
	localparam logic [KindW-1:0] KIND_START_CODON = 3'd4;
	localparam logic [KindW-1:0] KIND_STOP_CODON  = 3'd5;

	localparam logic [FrameW-1:0] FRAME_UNSET = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_FILTER_ENABLE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_RANGE_LOW     = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RANGE_HIGH    = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_CHROM_INDEX   = 2'd3;

	localparam logic signed [DataW-1:0] RANGE_HIGH_RESET = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [KindW-1:0]         feature_kind;
		logic signed [DataW-1:0]  start_code;
		logic signed [DataW-1:0]  length_delta;
		logic                     strand_minus;
		logic [FrameW-1:0]        frame;
		logic [SeqW-1:0]          seq_number;
	} item_t;

	typedef struct packed {
		logic signed [DataW-1:0]  start_coord;
		logic signed [DataW-1:0]  end_pos;
		logic                     strand_minus;
		logic [FrameW-1:0]        frame;
		logic                     keep;
	} result_t;

	typedef struct packed {
		logic                     filter_enable;
		logic signed [DataW-1:0]  range_low;
		logic signed [DataW-1:0]  range_high;
		logic [SeqW-1:0]          chrom_index;
	} cfg_t;

endpackage

FILE: rtl/gcdd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the filter settings written through the plain write port.
// ----------------------------------------------------------------------------
module gcdd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gcdd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [gcdd_pkg::DataW-1:0]        cfg_wdata,
	output gcdd_pkg::cfg_t                    cfg
);
	import gcdd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_enable <= 1'b0;
			cfg_q.range_low     <= '0;
			cfg_q.range_high    <= RANGE_HIGH_RESET;
			cfg_q.chrom_index   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_ENABLE: cfg_q.filter_enable <= cfg_wdata[0];
				CFG_RANGE_LOW:     cfg_q.range_low     <= $signed(cfg_wdata);
				CFG_RANGE_HIGH:    cfg_q.range_high    <= $signed(cfg_wdata);
				CFG_CHROM_INDEX:   cfg_q.chrom_index   <= cfg_wdata[SeqW-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/gcdd_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one request and holds it until the result register can take it.
// ----------------------------------------------------------------------------
module gcdd_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  gcdd_pkg::item_t item_in,
	input  logic            res_free,
	output logic            valid_s1,
	output gcdd_pkg::item_t item_s1
);
	import gcdd_pkg::*;

	logic load;

	assign in_stall = valid_s1 && !res_free;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (res_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

FILE: rtl/gcdd_core.sv
// ----------------------------------------------------------------------------
// Decoder core
// Holds the base and strand state and rebuilds positions from one record.
// ----------------------------------------------------------------------------
module gcdd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  gcdd_pkg::item_t   item,
	input  gcdd_pkg::cfg_t    cfg,
	output gcdd_pkg::result_t res
);
	import gcdd_pkg::*;

	logic [DataW-1:0] transcript_base_q;
	logic [DataW-1:0] exon_base_q;
	logic             first_exon_pending_q;
	logic             strand_minus_q;

	logic [DataW-1:0] start_w;
	logic             strand_w;
	logic [FrameW-1:0] frame_w;
	logic             in_range;
	logic             chrom_ok;

	always_comb begin
		strand_w = strand_minus_q;
		unique case (item.feature_kind)
			KIND_GENE: begin
				start_w  = item.start_code;
				strand_w = item.strand_minus;
			end
			KIND_TRANSCRIPT: start_w = item.start_code + transcript_base_q;
			KIND_EXON: begin
				if (!strand_minus_q || first_exon_pending_q) begin
					start_w = exon_base_q + item.start_code;
				end else begin
					start_w = exon_base_q - item.start_code;
				end
			end
			default: start_w = item.start_code + transcript_base_q;
		endcase
	end

	always_comb begin
		case (item.feature_kind) inside
			KIND_CDS, KIND_START_CODON, KIND_STOP_CODON: frame_w = item.frame;
			default: frame_w = FRAME_UNSET;
		endcase
	end

	assign in_range = ($signed(start_w) >= cfg.range_low)
		&& ($signed(start_w) <= cfg.range_high);
	assign chrom_ok = {1'b0, item.seq_number} == ({1'b0, cfg.chrom_index} + 9'd1);

	assign res.start_coord  = $signed(start_w);
	assign res.end_pos      = $signed(start_w + item.length_delta);
	assign res.strand_minus = strand_w;
	assign res.frame        = frame_w;
	assign res.keep         = !cfg.filter_enable || (in_range && chrom_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transcript_base_q    <= '0;
			exon_base_q          <= '0;
			first_exon_pending_q <= 1'b0;
			strand_minus_q       <= 1'b0;
		end else if (fire) begin
			unique case (item.feature_kind)
				KIND_GENE: begin
					transcript_base_q <= start_w;
					strand_minus_q    <= item.strand_minus;
				end
				KIND_TRANSCRIPT: begin
					transcript_base_q    <= start_w;
					exon_base_q          <= start_w;
					first_exon_pending_q <= 1'b1;
				end
				KIND_EXON: begin
					exon_base_q          <= start_w;
					first_exon_pending_q <= 1'b0;
				end
				default: begin
					transcript_base_q <= transcript_base_q;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_gene_strand: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.feature_kind == KIND_GENE |=> strand_minus_q == $past(item.strand_minus))
		else $error("strand not taken from gene record");
	a_transcript_bases: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.feature_kind == KIND_TRANSCRIPT
		|=> first_exon_pending_q && exon_base_q == transcript_base_q)
		else $error("transcript record did not align bases");
	a_exon_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.feature_kind == KIND_EXON |=> !first_exon_pending_q)
		else $error("first exon flag not cleared");
	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(transcript_base_q) && $stable(exon_base_q)
			&& $stable(strand_minus_q))
		else $error("state changed without a record");
`endif

endmodule

FILE: rtl/gtf_coordinate_delta_decoder.sv
// ----------------------------------------------------------------------------
// Annotation coordinate delta decoder
// Rebuilds absolute start and end positions of annotation records.
// ----------------------------------------------------------------------------
// A request passes through the input register and then the result register
// on its way to the outputs. Throughput: one request per cycle while the output
// is not stalled, set by the single decode step between the two registers.
// Reset clears all valid flags, the bases and the strand (plus) and returns
// the filter settings to their defaults; no clearing pass is needed.
module gtf_coordinate_delta_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gcdd_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [gcdd_pkg::DataW-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [gcdd_pkg::KindW-1:0]            feature_kind,
	input  logic signed [gcdd_pkg::DataW-1:0]     start_code,
	input  logic signed [gcdd_pkg::DataW-1:0]     length_delta,
	input  logic                                  strand_minus_in,
	input  logic [gcdd_pkg::FrameW-1:0]           frame_in,
	input  logic [gcdd_pkg::SeqW-1:0]             seq_number,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [gcdd_pkg::DataW-1:0]     start_coord,
	output logic signed [gcdd_pkg::DataW-1:0]     end_pos,
	output logic                                  strand_minus_out,
	output logic [gcdd_pkg::FrameW-1:0]           frame_out,
	output logic                                  keep
);
	import gcdd_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    res_free;
	logic    fire;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	assign item_in.feature_kind = feature_kind;
	assign item_in.start_code   = start_code;
	assign item_in.length_delta = length_delta;
	assign item_in.strand_minus = strand_minus_in;
	assign item_in.frame        = frame_in;
	assign item_in.seq_number   = seq_number;

	assign res_free = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && res_free;

	gcdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gcdd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.res_free (res_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gcdd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign start_coord      = res_s2.start_coord;
	assign end_pos          = res_s2.end_pos;
	assign strand_minus_out = res_s2.strand_minus;
	assign frame_out        = res_s2.frame;
	assign keep             = res_s2.keep;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");
	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("decoded request lost");
	a_keep_open: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !cfg.filter_enable |-> keep)
		else $error("record dropped with filter disabled");
`endif

endmodule

FILE: sim/tb_gtf_coordinate_delta_decoder.sv
// ----------------------------------------------------------------------------
// Coordinate delta decoder testbench
// Sends annotation records through the decoder with random sender gaps and
// receiver stalls. An in-bench decoder tracks the bases, strand and filter
// settings, and every result is compared field by field with its prediction.
// ----------------------------------------------------------------------------
module tb_gtf_coordinate_delta_decoder;

	import gcdd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [KindW-1:0] KIND_OTHER   = 3'd6;
	localparam logic [KindW-1:0] KIND_UNKNOWN = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = CFG_FILTER_ENABLE;
	logic [DataW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KindW-1:0] feature_kind = KIND_GENE;
	logic signed [DataW-1:0] start_code = '0;
	logic signed [DataW-1:0] length_delta = '0;
	logic strand_minus_in = 1'b0;
	logic [FrameW-1:0] frame_in = '0;
	logic [SeqW-1:0] seq_number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DataW-1:0] start_coord;
	logic signed [DataW-1:0] end_pos;
	logic strand_minus_out;
	logic [FrameW-1:0] frame_out;
	logic keep;

	gtf_coordinate_delta_decoder u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.feature_kind     (feature_kind),
		.start_code       (start_code),
		.length_delta     (length_delta),
		.strand_minus_in  (strand_minus_in),
		.frame_in         (frame_in),
		.seq_number       (seq_number),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.start_coord      (start_coord),
		.end_pos          (end_pos),
		.strand_minus_out (strand_minus_out),
		.frame_out        (frame_out),
		.keep             (keep)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the block should hold it.
	cfg_t cur_cfg = '{1'b0, '0, RANGE_HIGH_RESET, '0};
	logic [DataW-1:0] tx_base = '0;
	logic [DataW-1:0] ex_base = '0;
	logic first_exon_open = 1'b0;
	logic strand_held = 1'b0;

	result_t expected_records[$];
	result_t want;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	bit steady = 1'b0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;

	function automatic result_t decode_record(item_t r);
		result_t o;
		logic [DataW-1:0] s;
		logic in_range;
		logic chrom_hit;
		case (r.feature_kind)
			KIND_GENE: begin
				strand_held = r.strand_minus;
				s = r.start_code;
				tx_base = s;
			end
			KIND_TRANSCRIPT: begin
				s = r.start_code + tx_base;
				tx_base = s;
				ex_base = s;
				first_exon_open = 1'b1;
			end
			KIND_EXON: begin
				if (!strand_held || first_exon_open) begin
					s = r.start_code + ex_base;
				end else begin
					s = ex_base - r.start_code;
				end
				ex_base = s;
				first_exon_open = 1'b0;
			end
			default: begin
				s = r.start_code + tx_base;
			end
		endcase
		o.start_coord = s;
		o.end_pos = s + r.length_delta;
		o.strand_minus = strand_held;
		if (r.feature_kind == KIND_CDS || r.feature_kind == KIND_START_CODON ||
				r.feature_kind == KIND_STOP_CODON) begin
			o.frame = r.frame;
		end else begin
			o.frame = FRAME_UNSET;
		end
		in_range = $signed(s) >= $signed(cur_cfg.range_low) &&
			$signed(s) <= $signed(cur_cfg.range_high);
		chrom_hit = {1'b0, r.seq_number} == ({1'b0, cur_cfg.chrom_index} + 9'd1);
		o.keep = cur_cfg.filter_enable ? (in_range && chrom_hit) : 1'b1;
		return o;
	endfunction

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_records.size() == 0) begin
					$error("result with none expected: start_coord %0d", start_coord);
					errors++;
				end else begin
					want = expected_records.pop_front();
					if (start_coord !== want.start_coord) begin
						$error("start_coord: expected %0d, got %0d", want.start_coord,
							start_coord);
						errors++;
					end
					if (end_pos !== want.end_pos) begin
						$error("end_pos: expected %0d, got %0d", want.end_pos, end_pos);
						errors++;
					end
					if (strand_minus_out !== want.strand_minus) begin
						$error("strand_minus_out: expected %0d, got %0d",
							want.strand_minus, strand_minus_out);
						errors++;
					end
					if (frame_out !== want.frame) begin
						$error("frame_out: expected %0d, got %0d", want.frame, frame_out);
						errors++;
					end
					if (keep !== want.keep) begin
						$error("keep: expected %0d, got %0d", want.keep, keep);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_records.push_back(decode_record({feature_kind, start_code,
					length_delta, strand_minus_in, frame_in, seq_number}));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_gtf_coordinate_delta_decoder: errors");
			$finish;
		end
	end

	// The receiver switches among free flow, light, heavy and periodic stalls.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= cycles[2];
		endcase
	end

	task automatic post_record(logic [KindW-1:0] kind, logic signed [DataW-1:0] code,
			logic signed [DataW-1:0] len, logic strand, logic [FrameW-1:0] frame,
			logic [SeqW-1:0] seq);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		feature_kind <= kind;
		start_code <= code;
		length_delta <= len;
		strand_minus_in <= strand;
		frame_in <= frame;
		seq_number <= seq;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
	endtask

	task automatic write_settings(logic fe, logic signed [DataW-1:0] lo,
			logic signed [DataW-1:0] hi, logic [SeqW-1:0] ci);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_index <= CFG_FILTER_ENABLE;
		cfg_wdata <= {{(DataW-1){1'b0}}, fe};
		@(posedge clk);
		cfg_index <= CFG_RANGE_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= CFG_RANGE_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_index <= CFG_CHROM_INDEX;
		cfg_wdata <= {{(DataW-SeqW){1'b0}}, ci};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cfg.filter_enable = fe;
		cur_cfg.range_low = lo;
		cur_cfg.range_high = hi;
		cur_cfg.chrom_index = ci;
	endtask

	function automatic logic [DataW-1:0] pick_offset(int unsigned span);
		if ($urandom_range(0, 9) == 0) begin
			return $urandom;
		end
		return $urandom_range(0, span);
	endfunction

	// One gene with its transcripts, exons, coding records and occasional other records, in file order.
	task automatic gene_walk(logic [SeqW-1:0] seq);
		int unsigned n_ex;
		post_record(KIND_GENE, $urandom_range(0, 2000000), $urandom_range(0, 100000),
			1'($urandom_range(0, 1)), FrameW'($urandom_range(0, 3)), seq);
		repeat ($urandom_range(1, 3)) begin
			post_record(KIND_TRANSCRIPT, pick_offset(5000), $urandom_range(0, 50000),
				1'($urandom_range(0, 1)), FrameW'($urandom_range(0, 3)), seq);
			n_ex = $urandom_range(1, 6);
			repeat (n_ex) begin
				post_record(KIND_EXON, pick_offset(20000), $urandom_range(0, 3000),
					1'($urandom_range(0, 1)), FrameW'($urandom_range(0, 3)), seq);
				if ($urandom_range(0, 1)) begin
					post_record(KIND_CDS, pick_offset(20000), $urandom_range(0, 3000),
						1'($urandom_range(0, 1)), FrameW'($urandom_range(0, 2)), seq);
				end
			end
			post_record(KIND_START_CODON, pick_offset(20000), 2, 1'($urandom_range(0, 1)),
				FrameW'($urandom_range(0, 2)), seq);
			post_record(KIND_STOP_CODON, pick_offset(40000), 2, 1'($urandom_range(0, 1)),
				FrameW'($urandom_range(0, 2)), seq);
			if ($urandom_range(0, 2) == 0) begin
				post_record(KIND_OTHER, pick_offset(40000), $urandom_range(0, 500),
					1'($urandom_range(0, 1)), FrameW'($urandom_range(0, 3)), seq);
			end
		end
	endtask

	// Records that arrive before any gene see plus strand and zero bases.
	task automatic test_reset_state();
		post_record(KIND_EXON, 100, 10, 1'b1, 2'd0, 8'd1);
		post_record(KIND_EXON, 5, 0, 1'b0, 2'd0, 8'd1);
		post_record(KIND_CDS, 7, 3, 1'b1, 2'd1, 8'd0);
	endtask

	task automatic test_kinds_and_frames();
		post_record(KIND_GENE, 32'sh7FFF_FFFF, 1, 1'b1, 2'd0, 8'd255);
		post_record(KIND_TRANSCRIPT, 1, 32'sh7FFF_FFFF, 1'b0, 2'd3, 8'd0);
		post_record(KIND_EXON, 10, 5, 1'b0, 2'd2, 8'd1);
		post_record(KIND_EXON, 3, 5, 1'b0, 2'd1, 8'd1);
		post_record(KIND_EXON, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 2'd0, 8'd1);
		post_record(KIND_CDS, 0, 0, 1'b0, 2'd0, 8'd1);
		post_record(KIND_CDS, 1, 0, 1'b0, 2'd1, 8'd1);
		post_record(KIND_CDS, 2, 0, 1'b0, 2'd2, 8'd1);
		post_record(KIND_CDS, 3, 0, 1'b0, 2'd3, 8'd1);
		post_record(KIND_START_CODON, 4, 2, 1'b0, 2'd2, 8'd1);
		post_record(KIND_STOP_CODON, 5, 2, 1'b0, 2'd3, 8'd1);
		post_record(KIND_OTHER, 6, 9, 1'b0, 2'd1, 8'd1);
		post_record(KIND_UNKNOWN, 7, 9, 1'b1, 2'd0, 8'd1);
		post_record(KIND_GENE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 2'd3, 8'd128);
		post_record(KIND_TRANSCRIPT, -5, 0, 1'b1, 2'd0, 8'd1);
		post_record(KIND_EXON, 0, 0, 1'b1, 2'd0, 8'd1);
		post_record(KIND_EXON, 32'shFFFF_FFFF, 32'sh8000_0000, 1'b1, 2'd0, 8'd1);
	endtask

	task automatic test_filter_bounds();
		write_settings(1'b1, -100, 100000, 8'd0);
		post_record(KIND_GENE, -100, 1, 1'b0, 2'd0, 8'd1);
		post_record(KIND_GENE, -101, 1, 1'b0, 2'd0, 8'd1);
		post_record(KIND_GENE, 100000, 1, 1'b0, 2'd0, 8'd1);
		post_record(KIND_GENE, 100001, 1, 1'b0, 2'd0, 8'd1);
		post_record(KIND_GENE, 50, 1, 1'b0, 2'd0, 8'd0);
		post_record(KIND_GENE, 50, 1, 1'b0, 2'd0, 8'd2);
		write_settings(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'd254);
		post_record(KIND_GENE, 32'sh8000_0000, 0, 1'b1, 2'd0, 8'd255);
		post_record(KIND_GENE, 32'sh7FFF_FFFF, 0, 1'b0, 2'd0, 8'd255);
		// An index of 255 matches no chromosome at all: the sum is taken in nine bits and does not wrap.
		write_settings(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'd255);
		post_record(KIND_GENE, 0, 0, 1'b0, 2'd0, 8'd0);
		post_record(KIND_GENE, 0, 0, 1'b0, 2'd0, 8'd255);
		write_settings(1'b1, 10, 5, 8'd0);
		post_record(KIND_GENE, 7, 0, 1'b0, 2'd0, 8'd1);
	endtask

	task automatic test_annotation_walks();
		write_settings(1'b0, 0, RANGE_HIGH_RESET, 8'd0);
		steady = 1'b1;
		repeat (8) gene_walk(SeqW'($urandom_range(0, 255)));
		steady = 1'b0;
		repeat (22) gene_walk(SeqW'($urandom_range(0, 255)));
	endtask

	task automatic test_filter_walks();
		logic signed [DataW-1:0] lo;
		logic [SeqW-1:0] ci;
		for (int k = 0; k < 5; k++) begin
			lo = $urandom_range(0, 1000000);
			case (k)
				0: ci = 8'd0;
				1: ci = 8'd254;
				2: ci = 8'd255;
				default: ci = SeqW'($urandom_range(0, 255));
			endcase
			if (k == 3) begin
				write_settings(1'b1, lo + 500000, lo, ci);
			end else begin
				write_settings(1'b1, lo, lo + $urandom_range(0, 1500000), ci);
			end
			repeat (4) gene_walk(SeqW'($urandom_range(0, 1) ? ci + 8'd1 :
				$urandom_range(0, 255)));
		end
	endtask

	// Unordered records with full-width values, the filter off and then on.
	task automatic test_noise();
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
		for (int k = 0; k < 2; k++) begin
			a = $urandom;
			b = $urandom;
			if (k == 0) begin
				write_settings(1'b0, a, b, SeqW'($urandom_range(0, 255)));
			end else begin
				write_settings(1'b1, (a < b) ? a : b, (a < b) ? b : a,
					SeqW'($urandom_range(0, 255)));
			end
			repeat (175) begin
				post_record(KindW'($urandom_range(0, 7)), $urandom_range(0, 1) ? $urandom :
					$urandom_range(0, 30000), $urandom, 1'($urandom_range(0, 1)),
					FrameW'($urandom_range(0, 3)), SeqW'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_kinds_and_frames();
		test_filter_bounds();
		test_annotation_walks();
		test_filter_walks();
		test_noise();
		drain_pipeline();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb_gtf_coordinate_delta_decoder: clean");
		end else begin
			$display("tb_gtf_coordinate_delta_decoder: errors");
		end
		$finish;
	end

endmodule
